// ===== src/wavelet_lifting_schedule_generator_defines.svh =====
// Assertion macros shared by the schedule generator RTL.
`ifndef WAVELET_LIFTING_SCHEDULE_GENERATOR_DEFINES_SVH
`define WAVELET_LIFTING_SCHEDULE_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define WLSG_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wlsg assertion failed");
`define WLSG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wlsg assertion failed");
`else
`define WLSG_ASSERT_SAME(lbl, ante, cons)
`define WLSG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/wlsg_pkg.sv =====
// Types and constants of the wavelet lifting schedule generator.
`timescale 1ns / 1ps
package wlsg_pkg;
	localparam int IN_DIM_W  = 16;
	localparam int DIM_W     = 17;
	localparam int STRIDE_W  = 32;
	localparam int CODE_W    = 64;
	localparam int LEVEL_W   = 5;
	localparam int AXIS_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int MAX_STEPS_DEF = 32;

	localparam logic [1:0] DIGIT_MARK = 2'd3;
	localparam logic [CODE_W-1:0] CODE_REWIND = 64'd3;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_LIMIT     = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_LOAD,
		ACT_MARK,
		ACT_STEP,
		ACT_FINISH
	} action_t;

	typedef struct packed {
		logic [AXIS_W-1:0]   axis;
		logic [DIM_W-1:0]    grid_dim_x;
		logic [DIM_W-1:0]    grid_dim_y;
		logic [DIM_W-1:0]    grid_dim_z;
		logic [STRIDE_W-1:0] grid_stride_x;
		logic [STRIDE_W-1:0] grid_stride_y;
		logic [STRIDE_W-1:0] grid_stride_z;
		logic                step_valid;
		logic [STATUS_W-1:0] status;
		logic [CODE_W-1:0]   remaining_order;
		logic                last;
	} rec_t;

	// Result of the shared axis unit for the axis being stepped.
	typedef struct packed {
		logic [DIM_W-1:0]    odd;
		logic [DIM_W-1:0]    half;
		logic [STRIDE_W-1:0] stride;
	} axis_upd_t;
endpackage

// ===== src/wlsg_if.sv =====
// Request and response channel interfaces of the schedule generator.
`timescale 1ns / 1ps
interface wlsg_req_if;
	logic                            valid;
	logic                            ready;
	logic [wlsg_pkg::IN_DIM_W-1:0]   dims_x;
	logic [wlsg_pkg::IN_DIM_W-1:0]   dims_y;
	logic [wlsg_pkg::IN_DIM_W-1:0]   dims_z;
	logic [wlsg_pkg::CODE_W-1:0]     order_code;
	logic [wlsg_pkg::LEVEL_W-1:0]    level_count;

	modport source (output valid, dims_x, dims_y, dims_z, order_code, level_count,
		input ready);
	modport sink (input valid, dims_x, dims_y, dims_z, order_code, level_count,
		output ready);
endinterface

interface wlsg_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [wlsg_pkg::AXIS_W-1:0]     axis;
	logic [wlsg_pkg::DIM_W-1:0]      grid_dim_x;
	logic [wlsg_pkg::DIM_W-1:0]      grid_dim_y;
	logic [wlsg_pkg::DIM_W-1:0]      grid_dim_z;
	logic [wlsg_pkg::STRIDE_W-1:0]   grid_stride_x;
	logic [wlsg_pkg::STRIDE_W-1:0]   grid_stride_y;
	logic [wlsg_pkg::STRIDE_W-1:0]   grid_stride_z;
	logic                            step_valid;
	logic [wlsg_pkg::STATUS_W-1:0]   status;
	logic [wlsg_pkg::CODE_W-1:0]     remaining_order;
	logic                            last;

	modport source (output valid, axis, grid_dim_x, grid_dim_y, grid_dim_z,
		grid_stride_x, grid_stride_y, grid_stride_z, step_valid, status,
		remaining_order, last, input ready);
	modport sink (input valid, axis, grid_dim_x, grid_dim_y, grid_dim_z,
		grid_stride_x, grid_stride_y, grid_stride_z, step_valid, status,
		remaining_order, last, output ready);
endinterface

// ===== src/wavelet_lifting_schedule_generator.sv =====
// Top level of the wavelet lifting schedule generator.
// The req channel takes one word with the volume extents, a base-4 order code
// (low digit first: X, Y, Z, level mark) and a level count. The rsp channel
// returns one word per lifting step with the axis and the working grid's
// extents and strides; the final word carries last, the status and the order
// code left over. A walk with no step returns a single word with step_valid
// low. Both channels use valid/ready handshakes.
// A small sequencer consumes one order digit per cycle through one shared
// axis unit, unless a record must wait for room in the output register.
// Each record is held back until it is known whether it is the last one, so
// the first word reaches the output register when the next step or the end of
// the walk is reached.
// The block takes no new request while a walk is running; it is ready again
// as soon as the final word is in the output register.
// A receiver stall only holds the sequencer when a record must move into a
// full output register. Reset empties the output register and returns the
// sequencer to idle; no state is kept between requests.
`timescale 1ns / 1ps
`include "wavelet_lifting_schedule_generator_defines.svh"
module wavelet_lifting_schedule_generator #(
	parameter int MAX_STEPS = wlsg_pkg::MAX_STEPS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	wlsg_req_if.sink   req,
	wlsg_rsp_if.source rsp
);
	import wlsg_pkg::*;

	localparam int N_W = $clog2(MAX_STEPS + 1);

	state_t  state_q, state_d;
	action_t act;
	logic [STATUS_W-1:0] fin_status;

	logic [DIM_W-1:0]    pend_q [3];
	logic [DIM_W-1:0]    odd_q  [3];
	logic [STRIDE_W-1:0] ps_q   [3];
	logic [STRIDE_W-1:0] gs_q   [3];
	logic [CODE_W-1:0]   code_q;
	logic [CODE_W-1:0]   saved_q;
	logic [CODE_W-1:0]   code_shift;
	logic [LEVEL_W-1:0]  levels_q;
	logic [LEVEL_W-1:0]  level_q;
	logic [N_W-1:0]      n_q;
	logic                held_q;
	rec_t                held_rec_q;
	rec_t                out_rec_q;
	rec_t                final_rec;
	rec_t                step_rec;
	logic                out_valid_q;
	logic                out_free;
	logic                load_out;
	logic [1:0]          digit;
	axis_upd_t           upd;

	assign digit      = code_q[1:0];
	assign code_shift = code_q >> 2;
	assign out_free   = !out_valid_q || rsp.ready;

	wlsg_axis_unit u_axis (
		.pend   (pend_q[digit]),
		.stride (ps_q[digit]),
		.upd    (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		logic finish;
		finish     = 1'b0;
		state_d    = state_q;
		act        = ACT_NONE;
		fin_status = STATUS_OK;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					act     = ACT_LOAD;
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (level_q >= levels_q) begin
					finish = 1'b1;
				end else if (code_q == '0) begin
					finish     = 1'b1;
					fin_status = STATUS_EXHAUSTED;
				end else if (digit == DIGIT_MARK) begin
					act = ACT_MARK;
				end else if (n_q >= N_W'(MAX_STEPS)) begin
					// The step digit is left in the code.
					finish     = 1'b1;
					fin_status = STATUS_LIMIT;
				end else if (!held_q || out_free) begin
					act = ACT_STEP;
				end
				if (finish && out_free) begin
					act     = ACT_FINISH;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign req.ready = (state_q == ST_IDLE);

	always_comb begin
		if (held_q) begin
			final_rec = held_rec_q;
		end else begin
			final_rec = '0;
		end
		final_rec.status          = fin_status;
		final_rec.remaining_order = code_q;
		final_rec.last            = 1'b1;
	end

	// Record of the step being taken, built from the grid as it stands before it.
	always_comb begin
		step_rec               = '0;
		step_rec.axis          = digit;
		step_rec.grid_dim_x    = odd_q[0];
		step_rec.grid_dim_y    = odd_q[1];
		step_rec.grid_dim_z    = odd_q[2];
		step_rec.grid_stride_x = gs_q[0];
		step_rec.grid_stride_y = gs_q[1];
		step_rec.grid_stride_z = gs_q[2];
		step_rec.step_valid    = 1'b1;
	end

	assign load_out = (act == ACT_FINISH) || ((act == ACT_STEP) && held_q);

	// Walk state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= 1'b0;
			level_q <= '0;
			n_q     <= '0;
		end else begin
			case (act)
				ACT_LOAD: begin
					held_q  <= 1'b0;
					level_q <= '0;
					n_q     <= '0;
				end
				ACT_MARK: begin
					level_q <= level_q + 1'b1;
				end
				ACT_STEP: begin
					held_q <= 1'b1;
					n_q    <= n_q + 1'b1;
				end
				ACT_FINISH: begin
					held_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (act)
			ACT_LOAD: begin
				pend_q[0] <= {1'b0, req.dims_x};
				pend_q[1] <= {1'b0, req.dims_y};
				pend_q[2] <= {1'b0, req.dims_z};
				odd_q[0]  <= {1'b0, req.dims_x};
				odd_q[1]  <= {1'b0, req.dims_y};
				odd_q[2]  <= {1'b0, req.dims_z};
				for (int i = 0; i < 3; i++) begin
					ps_q[i] <= STRIDE_W'(1);
					gs_q[i] <= STRIDE_W'(1);
				end
				code_q   <= req.order_code;
				saved_q  <= req.order_code;
				levels_q <= req.level_count;
			end
			ACT_MARK: begin
				// A lone mark left after a mark repeats the saved order.
				if (code_shift == CODE_REWIND) begin
					code_q <= saved_q;
				end else begin
					code_q  <= code_shift;
					saved_q <= code_shift;
				end
				for (int i = 0; i < 3; i++) begin
					gs_q[i]  <= ps_q[i];
					odd_q[i] <= pend_q[i];
				end
			end
			ACT_STEP: begin
				code_q        <= code_shift;
				held_rec_q    <= step_rec;
				odd_q[digit]  <= upd.odd;
				pend_q[digit] <= upd.half;
				ps_q[digit]   <= upd.stride;
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (act == ACT_FINISH) begin
			out_rec_q <= final_rec;
		end else if (load_out) begin
			out_rec_q <= held_rec_q;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.axis            = out_rec_q.axis;
	assign rsp.grid_dim_x      = out_rec_q.grid_dim_x;
	assign rsp.grid_dim_y      = out_rec_q.grid_dim_y;
	assign rsp.grid_dim_z      = out_rec_q.grid_dim_z;
	assign rsp.grid_stride_x   = out_rec_q.grid_stride_x;
	assign rsp.grid_stride_y   = out_rec_q.grid_stride_y;
	assign rsp.grid_stride_z   = out_rec_q.grid_stride_z;
	assign rsp.step_valid      = out_rec_q.step_valid;
	assign rsp.status          = out_rec_q.status;
	assign rsp.remaining_order = out_rec_q.remaining_order;
	assign rsp.last            = out_rec_q.last;

	`WLSG_ASSERT_SAME(a_step_count_bound, state_q == ST_WALK, n_q <= N_W'(MAX_STEPS))
	`WLSG_ASSERT_SAME(a_nonlast_in_walk, rsp.valid && !rsp.last, state_q == ST_WALK)
	`WLSG_ASSERT_SAME(a_nonlast_clean, rsp.valid && !rsp.last, rsp.status == STATUS_OK && rsp.remaining_order == '0)
	`WLSG_ASSERT_SAME(a_empty_is_last, rsp.valid && !rsp.step_valid, rsp.last)
	`WLSG_ASSERT_NEXT(a_load_starts_walk, req.valid && req.ready, state_q == ST_WALK && !held_q)
endmodule

// ===== src/wlsg_axis_unit.sv =====
// Shared axis unit: rounds an extent up to odd, halves it and doubles the stride.
`timescale 1ns / 1ps
module wlsg_axis_unit (
	input  logic [wlsg_pkg::DIM_W-1:0]    pend,
	input  logic [wlsg_pkg::STRIDE_W-1:0] stride,
	output wlsg_pkg::axis_upd_t           upd
);
	import wlsg_pkg::*;

	logic [DIM_W-1:0] odd;
	logic [DIM_W:0]   sum;

	// An even extent (zero included) grows by one to become odd.
	assign odd = pend + {{(DIM_W-1){1'b0}}, ~pend[0]};
	assign sum = {1'b0, odd} + {{DIM_W{1'b0}}, 1'b1};

	assign upd.odd    = odd;
	assign upd.half   = sum[DIM_W:1];
	assign upd.stride = {stride[STRIDE_W-2:0], 1'b0};
endmodule

// ===== bench/lifting_schedule_checker.sv =====
// Checker that predicts the lifting schedule of each request and compares the returned words.
`timescale 1ns / 1ps
module lifting_schedule_checker #(
	parameter int MAX_STEPS = wlsg_pkg::MAX_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	wlsg_req_if  req,
	wlsg_rsp_if  rsp,
	output int   mismatch_count,
	output int   records_due
);
	import wlsg_pkg::*;

	rec_t expected_steps[$];
	rec_t got;
	rec_t want;
	int   errors = 0;

	function automatic string fmt_rec(rec_t r);
		return $sformatf({"axis=%0d dim=%0d/%0d/%0d stride=%0h/%0h/%0h ",
			"step_valid=%0b status=%0d remaining=%016h last=%0b"},
			r.axis, r.grid_dim_x, r.grid_dim_y, r.grid_dim_z,
			r.grid_stride_x, r.grid_stride_y, r.grid_stride_z,
			r.step_valid, r.status, r.remaining_order, r.last);
	endfunction

	// Walks the order code and queues one word per lifting step. Each word is held back
	// one step so that the final one can take the status and the code left over.
	function automatic void predict_schedule(input logic [IN_DIM_W-1:0] dx,
		input logic [IN_DIM_W-1:0] dy, input logic [IN_DIM_W-1:0] dz,
		input logic [CODE_W-1:0] order, input logic [LEVEL_W-1:0] levels);
		logic [DIM_W-1:0]    pend[3];
		logic [DIM_W-1:0]    odd[3];
		logic [DIM_W-1:0]    gd[3];
		logic [STRIDE_W-1:0] ps[3];
		logic [STRIDE_W-1:0] gs[3];
		logic [CODE_W-1:0]   code;
		logic [CODE_W-1:0]   saved;
		logic [STATUS_W-1:0] status;
		logic [1:0]          d;
		rec_t                held;
		bit                  have_held;
		int                  level;
		int                  n;
		int                  i;
		pend[0] = {1'b0, dx};
		pend[1] = {1'b0, dy};
		pend[2] = {1'b0, dz};
		for (i = 0; i < 3; i++) begin
			odd[i] = pend[i];
			gd[i] = pend[i];
			ps[i] = 1;
			gs[i] = 1;
		end
		code = order;
		saved = order;
		status = STATUS_OK;
		held = '0;
		have_held = 0;
		level = 0;
		n = 0;
		while (level < int'(levels)) begin
			if (code == '0) begin
				status = STATUS_EXHAUSTED;
				break;
			end
			d = code[1:0];
			if (d == DIGIT_MARK) begin
				code = code >> 2;
				if (code == CODE_REWIND)
					code = saved;
				else
					saved = code;
				for (i = 0; i < 3; i++) begin
					gs[i] = ps[i];
					gd[i] = pend[i];
					odd[i] = pend[i];
				end
				level++;
			end else begin
				// The digit that hits the step limit stays in the code.
				if (n >= MAX_STEPS) begin
					status = STATUS_LIMIT;
					break;
				end
				code = code >> 2;
				if (have_held)
					expected_steps.push_back(held);
				held = '0;
				held.axis = d;
				held.grid_dim_x = gd[0];
				held.grid_dim_y = gd[1];
				held.grid_dim_z = gd[2];
				held.grid_stride_x = gs[0];
				held.grid_stride_y = gs[1];
				held.grid_stride_z = gs[2];
				held.step_valid = 1'b1;
				have_held = 1;
				n++;
				odd[d] = pend[d] + (pend[d][0] ? 17'd0 : 17'd1);
				for (i = 0; i < 3; i++)
					gd[i] = odd[i];
				pend[d] = (odd[d] + 17'd1) >> 1;
				ps[d] = ps[d] << 1;
			end
		end
		if (!have_held)
			held = '0;
		held.status = status;
		held.remaining_order = code;
		held.last = 1'b1;
		expected_steps.push_back(held);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				predict_schedule(req.dims_x, req.dims_y, req.dims_z, req.order_code,
					req.level_count);
			if (rsp.valid && rsp.ready) begin
				got.axis = rsp.axis;
				got.grid_dim_x = rsp.grid_dim_x;
				got.grid_dim_y = rsp.grid_dim_y;
				got.grid_dim_z = rsp.grid_dim_z;
				got.grid_stride_x = rsp.grid_stride_x;
				got.grid_stride_y = rsp.grid_stride_y;
				got.grid_stride_z = rsp.grid_stride_z;
				got.step_valid = rsp.step_valid;
				got.status = rsp.status;
				got.remaining_order = rsp.remaining_order;
				got.last = rsp.last;
				if (expected_steps.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: word with none expected: %s", $realtime, fmt_rec(got));
				end else begin
					want = expected_steps.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: word mismatch", $realtime);
							$display("  expected %s", fmt_rec(want));
							$display("  actual   %s", fmt_rec(got));
						end
					end
				end
			end
		end
		mismatch_count <= errors;
		records_due <= expected_steps.size();
	end
endmodule

// ===== bench/tb_top.sv =====
// Testbench top: drives schedule requests and receiver stalls and reports the verdict.
`timescale 1ns / 1ps
module tb_top;
	import wlsg_pkg::*;

	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   records_due;
	int   burst_left;

	wlsg_req_if req ();
	wlsg_rsp_if rsp ();

	wavelet_lifting_schedule_generator uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	lifting_schedule_checker #(
		.MAX_STEPS(MAX_STEPS_DEF)
	) sched_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.rsp           (rsp),
		.mismatch_count(mismatch_count),
		.records_due   (records_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("simulation failed");
		$finish;
	end

	// Receiver: modes change at random between always ready, short stalls and
	// long stalls.
	initial begin
		int  mode;
		int  mode_left;
		int  hold;
		logic lvl;
		mode = 0;
		mode_left = 0;
		hold = 0;
		lvl = 1'b0;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(100, 400);
			end
			mode_left--;
			if (hold == 0) begin
				lvl = !lvl;
				hold = lvl ? $urandom_range(1, 6) : $urandom_range(1, (mode == 2) ? 20 : 4);
			end
			hold--;
			rsp.ready <= (mode == 0) ? 1'b1 : lvl;
		end
	end

	function automatic logic [IN_DIM_W-1:0] pick_extent();
		case ($urandom_range(0, 5))
			0: return IN_DIM_W'(1);
			1: return 16'hFFFF;
			2: return IN_DIM_W'($urandom_range(1, 16));
			3: return IN_DIM_W'($urandom_range(1, 1024));
			default: return IN_DIM_W'($urandom_range(1, 65535));
		endcase
	endfunction

	// Builds a well-formed order: levels of up to four axis digits, each closed by a
	// mark, sometimes with a trailing rewind digit.
	function automatic void make_walk(output logic [CODE_W-1:0] code,
		output logic [LEVEL_W-1:0] lv, output int marks);
		logic [CODE_W-1:0] dig;
		int nd;
		int k;
		int s;
		int want;
		code = '0;
		nd = 0;
		marks = 0;
		want = $urandom_range(1, 16);
		while (marks < want && nd < 32) begin
			s = $urandom_range(0, 4);
			for (k = 0; k < s && nd < 31; k++) begin
				dig = CODE_W'($urandom_range(0, 2));
				code |= dig << (2 * nd);
				nd++;
			end
			dig = CODE_W'(DIGIT_MARK);
			code |= dig << (2 * nd);
			nd++;
			marks++;
		end
		if (nd < 32 && $urandom_range(0, 3) == 0) begin
			dig = CODE_W'(DIGIT_MARK);
			code |= dig << (2 * nd);
		end
		lv = LEVEL_W'(marks);
	endfunction

	task automatic send_volume_request(input logic [IN_DIM_W-1:0] dx,
		input logic [IN_DIM_W-1:0] dy, input logic [IN_DIM_W-1:0] dz,
		input logic [CODE_W-1:0] code, input logic [LEVEL_W-1:0] lv);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		req.valid <= 1'b1;
		req.dims_x <= dx;
		req.dims_y <= dy;
		req.dims_z <= dz;
		req.order_code <= code;
		req.level_count <= lv;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		burst_left--;
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		@(posedge clk);
		while (records_due != 0) @(posedge clk);
	endtask

	initial begin
		logic [CODE_W-1:0]  code;
		logic [LEVEL_W-1:0] lv;
		int k;
		int kind;
		int marks;
		int cut;
		arst_n = 1'b0;
		burst_left = 0;
		req.valid = 1'b0;
		req.dims_x = '0;
		req.dims_y = '0;
		req.dims_z = '0;
		req.order_code = '0;
		req.level_count = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// No levels, exhaustion, marks only, rewinds and the step limit.
		send_volume_request(1, 1, 1, 64'h0, 0);
		send_volume_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
		send_volume_request(2, 2, 2, 64'hE4, 0);
		send_volume_request(7, 8, 9, 64'h0, 1);
		send_volume_request(3, 3, 3, 64'h3, 2);
		send_volume_request(16'hFFFF, 16'hFFFE, 2, 64'hE4, 1);
		send_volume_request(16'hFFFF, 2, 3, 64'h1B, 1);
		send_volume_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 64'hCCCC_CCCC_CCCC_CCCC, 16);
		send_volume_request(2, 16'hFFFF, 5, 64'hF5555, 16);
		send_volume_request(100, 200, 300, 64'h5555_5555_5555_5555, 1);
		send_volume_request(16'hFFFF, 1, 16'hFFFE, 64'hAAAA_AAAA_AAAA_AAAA, 2);
		send_volume_request(9, 9, 9, 64'hEAAA_AAAA_AAAA_AAAA, 1);
		send_volume_request(4, 4, 4, 64'hF, 16);
		send_volume_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16);
		send_volume_request(1, 16'hFFFF, 1, 64'h1, 1);
		send_volume_request(16'hFFFE, 16'hFFFE, 16'hFFFE, 64'h0000_0000_00E4_39E4, 3);
		wait_drained();

		for (k = 0; k < 180; k++) begin
			if (k == 90)
				wait_drained();
			kind = $urandom_range(0, 99);
			make_walk(code, lv, marks);
			if (kind >= 85) begin
				code = {$urandom, $urandom};
				lv = LEVEL_W'($urandom_range(0, 16));
			end else if (kind >= 70) begin
				// Broken walks: too few marks, a cut-off code, or rewinds run to the limit.
				case ($urandom_range(0, 2))
					0: lv = (marks < 16) ? LEVEL_W'($urandom_range(marks + 1, 16))
						: LEVEL_W'(16);
					1: begin
						cut = $urandom_range(1, 31);
						code &= (64'd1 << (2 * cut)) - 64'd1;
					end
					default: lv = LEVEL_W'(16);
				endcase
			end
			send_volume_request(pick_extent(), pick_extent(), pick_extent(), code, lv);
		end
		wait_drained();
		repeat (50) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
